### rtl/core/tasd_pkg.sv
// Shared types and constants of the text animation stream decoder.
package tasd_pkg;

  typedef enum logic [2:0] {
    OP_WRITE    = 3'd0,
    OP_SKIP     = 3'd1,
    OP_HOME     = 3'd2,
    OP_SETW     = 3'd3,
    OP_SETH     = 3'd4,
    OP_END      = 3'd5,
    OP_BADMAGIC = 3'd6,
    OP_BADCOUNT = 3'd7
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  cnt;
    logic [7:0]  data;
    logic [13:0] delay;
  } cmd_t;

  localparam logic [2:0] KIND_CHAR      = 3'd0;
  localparam logic [2:0] KIND_FRAME     = 3'd1;
  localparam logic [2:0] KIND_MOVIE_END = 3'd2;
  localparam logic [2:0] KIND_BAD_MAGIC = 3'd3;
  localparam logic [2:0] KIND_USER_CHR  = 3'd4;

  localparam logic [7:0] MAGIC_BYTE = 8'h40;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] OPC_END    = 8'hF0;
  localparam logic [7:0] OPC_FRAME  = 8'hF1;

endpackage

### rtl/core/tasd_front.sv
// Front end: header parse and opcode classification into commands.
module tasd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    byte_in,
  input  logic          full,
  output logic          push,
  output tasd_pkg::cmd_t cmd
);
  import tasd_pkg::*;

  typedef enum logic [8:0] {
    PH_MAGIC   = 9'b000000001,
    PH_WIDTH   = 9'b000000010,
    PH_HEIGHT  = 9'b000000100,
    PH_COUNT   = 9'b000001000,
    PH_DATA    = 9'b000010000,
    PH_REPCHAR = 9'b000100000,
    PH_DELAY   = 9'b001000000,
    PH_HOME    = 9'b010000000,
    PH_HALT    = 9'b100000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  pend_cnt, pend_cnt_next;
  logic [7:0]  pend_delay, pend_delay_next;
  logic        cmd_en;
  logic        acc;
  logic [13:0] delay_x33;

  assign in_ready  = ~full;
  assign acc       = in_valid & ~full;
  assign push      = acc & cmd_en;
  assign delay_x33 = {1'b0, pend_delay, 5'b0} + {6'b0, pend_delay};

  always_comb begin
    phase_next      = phase;
    pend_cnt_next   = pend_cnt;
    pend_delay_next = pend_delay;
    cmd_en          = 1'b0;
    cmd.op          = OP_WRITE;
    cmd.cnt         = 6'd1;
    cmd.data        = byte_in;
    cmd.delay       = '0;
    unique case (phase)
      PH_MAGIC: begin
        if (byte_in == MAGIC_BYTE) begin
          phase_next = PH_WIDTH;
        end else begin
          cmd_en     = 1'b1;
          cmd.op     = OP_BADMAGIC;
          phase_next = PH_HALT;
        end
      end
      PH_WIDTH: begin
        cmd_en     = 1'b1;
        cmd.op     = OP_SETW;
        phase_next = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        cmd_en     = 1'b1;
        cmd.op     = OP_SETH;
        phase_next = PH_COUNT;
      end
      PH_COUNT: begin
        if (byte_in != 8'd0) begin
          cmd_en     = 1'b1;
          cmd.op     = OP_BADCOUNT;
          phase_next = PH_HALT;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        unique case (byte_in[7:4]) inside
          4'h8, 4'h9: begin
            cmd_en   = 1'b1;
            cmd.cnt  = {1'b0, byte_in[4:0]} + 6'd2;
            cmd.data = SPACE_CHAR;
          end
          4'hA: begin
            cmd_en  = 1'b1;
            cmd.op  = OP_SKIP;
            cmd.cnt = (byte_in[3:0] == 4'd0) ? 6'd16 : {2'b0, byte_in[3:0]};
          end
          4'hE: begin
            pend_cnt_next = (byte_in[3:0] == 4'd0) ? 5'd16 : {1'b0, byte_in[3:0]};
            phase_next    = PH_REPCHAR;
          end
          4'hF: begin
            if (byte_in == OPC_END) begin
              cmd_en     = 1'b1;
              cmd.op     = OP_END;
              phase_next = PH_HALT;
            end else if (byte_in == OPC_FRAME) begin
              phase_next = PH_DELAY;
            end else begin
              cmd_en = 1'b1;
            end
          end
          default: begin
            cmd_en = 1'b1;
          end
        endcase
      end
      PH_REPCHAR: begin
        cmd_en     = 1'b1;
        cmd.cnt    = {1'b0, pend_cnt};
        phase_next = PH_DATA;
      end
      PH_DELAY: begin
        pend_delay_next = byte_in;
        phase_next      = PH_HOME;
      end
      PH_HOME: begin
        cmd_en     = 1'b1;
        cmd.op     = OP_HOME;
        cmd.delay  = delay_x33;
        phase_next = PH_DATA;
      end
      PH_HALT: begin
        phase_next = PH_HALT;
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_MAGIC;
      pend_cnt   <= '0;
      pend_delay <= '0;
    end else if (acc) begin
      phase      <= phase_next;
      pend_cnt   <= pend_cnt_next;
      pend_delay <= pend_delay_next;
    end
  end

endmodule

### rtl/core/tasd_fifo.sv
// Command queue between the front end and the back end.
module tasd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tasd_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output tasd_pkg::cmd_t dout,
  output logic           empty
);
  import tasd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");
  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule

### rtl/core/tasd_back.sv
// Back end: cursor tracking and result emission, at most one result per cycle while the receiver accepts.
module tasd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  tasd_pkg::cmd_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     kind,
  output logic [7:0]     col,
  output logic [8:0]     row,
  output logic [7:0]     char_code,
  output logic [13:0]    delay_ms,
  output logic           last
);
  import tasd_pkg::*;

  logic [7:0] win_width, win_height;
  logic [7:0] cur_col, cur_col_next;
  logic [8:0] cur_row, cur_row_next;
  logic [5:0] rep;
  logic       adv, emit, run_last;
  logic [8:0] last_row, row_inc, col_p1, pos, pos_w, home_r;
  logic [7:0] cap;
  logic [2:0] kind_next;
  logic [7:0] col_out;
  logic [8:0] row_out;
  logic [7:0] char_out;
  logic [13:0] delay_out;
  logic        last_out;

  assign adv      = ~out_valid | out_ready;
  assign last_row = {1'b0, win_height} + 9'd1;
  assign row_inc  = (cur_row < last_row) ? cur_row + 9'd1 : cur_row;
  assign col_p1   = {1'b0, cur_col} + 9'd1;
  assign pos      = {1'b0, cur_col} + {3'b0, head.cnt};
  assign pos_w    = pos - {1'b0, win_width};
  assign cap      = (win_width == 8'd0) ? 8'd1 : win_width;
  assign home_r   = ({1'b0, head.data} + 9'd1 > last_row) ? last_row
                                                          : {1'b0, head.data} + 9'd1;
  assign run_last = (rep + 6'd1 == head.cnt);

  always_comb begin
    pop          = 1'b0;
    emit         = 1'b0;
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    kind_next    = KIND_CHAR;
    col_out      = '0;
    row_out      = '0;
    char_out     = '0;
    delay_out    = '0;
    last_out     = 1'b1;
    if (head_valid) begin
      unique case (head.op)
        OP_WRITE: begin
          if (adv) begin
            emit     = 1'b1;
            pop      = run_last;
            last_out = run_last;
            col_out  = cur_col;
            row_out  = cur_row;
            char_out = head.data;
            if (col_p1 > {1'b0, win_width}) begin
              cur_col_next = 8'd1;
              cur_row_next = row_inc;
            end else begin
              cur_col_next = col_p1[7:0];
            end
          end
        end
        OP_SKIP: begin
          pop = 1'b1;
          if (pos > {1'b0, win_width}) begin
            cur_row_next = row_inc;
            cur_col_next = (pos_w > {1'b0, cap}) ? cap : pos_w[7:0];
          end else begin
            cur_col_next = (pos > {1'b0, cap}) ? cap : pos[7:0];
          end
        end
        OP_SETW, OP_SETH: begin
          pop = 1'b1;
        end
        OP_HOME: begin
          if (adv) begin
            emit         = 1'b1;
            pop          = 1'b1;
            kind_next    = KIND_FRAME;
            col_out      = 8'd1;
            row_out      = home_r;
            delay_out    = head.delay;
            cur_col_next = 8'd1;
            cur_row_next = home_r;
          end
        end
        OP_END, OP_BADMAGIC, OP_BADCOUNT: begin
          if (adv) begin
            emit = 1'b1;
            pop  = 1'b1;
            case (head.op)
              OP_END:      kind_next = KIND_MOVIE_END;
              OP_BADMAGIC: kind_next = KIND_BAD_MAGIC;
              default:     kind_next = KIND_USER_CHR;
            endcase
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_width  <= '0;
      win_height <= '0;
      cur_col    <= 8'd1;
      cur_row    <= 9'd1;
      rep        <= '0;
      out_valid  <= 1'b0;
    end else begin
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      if (head_valid && head.op == OP_SETW) begin
        win_width <= head.data;
      end
      if (head_valid && head.op == OP_SETH) begin
        win_height <= head.data;
      end
      if (emit && head.op == OP_WRITE) begin
        rep <= run_last ? 6'd0 : rep + 6'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind      <= kind_next;
      col       <= col_out;
      row       <= row_out;
      char_code <= char_out;
      delay_ms  <= delay_out;
      last      <= last_out;
    end
  end

endmodule

### rtl/core/text_animation_stream_decoder_top.sv
// Top level of the text animation stream decoder.
// Input channel: in_valid/in_ready with byte_in, one stream byte per item,
// the four-byte header first, then opcode bytes.
// Output channel: out_valid/out_ready with kind, col, row, char_code,
// delay_ms and last; last marks the final result caused by one input byte.
// A byte is taken by the front end and turned into at most one command
// in a DEPTH-entry queue; with the queue empty, the command is written to the
// queue, and out_valid rises when the back end registers the first result.
// Throughput: one byte per cycle while the queue has room. The back end
// sends one result per cycle while the receiver accepts, so a space run or
// repeat run of n cells holds it until all are sent; bytes keep entering
// until the queue fills. Bytes with no result (header, skips, frame delay)
// still pass one queue slot each where they change the cursor or window size.
// Reset: synchronous rst clears the queue, the parse phase, the window size
// to zero and the cursor to column 1, row 1.
// When the receiver stalls, the output register holds its item, the back end
// stops, the queue fills and in_ready then drops.
// After the movie end or a header error, further bytes are taken and dropped.
module text_animation_stream_decoder_top #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  col,
  output logic [8:0]  row,
  output logic [7:0]  char_code,
  output logic [13:0] delay_ms,
  output logic        last
);
  import tasd_pkg::*;

  cmd_t cmd_in, cmd_head;
  logic push, pop, full, empty;

  tasd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .byte_in  (byte_in),
    .full     (full),
    .push     (push),
    .cmd      (cmd_in)
  );

  tasd_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (pop),
    .dout  (cmd_head),
    .empty (empty)
  );

  tasd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (~empty),
    .head       (cmd_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .col        (col),
    .row        (row),
    .char_code  (char_code),
    .delay_ms   (delay_ms),
    .last       (last)
  );

endmodule

### dv/text_animation_stream_decoder_checker.sv
// Checker for the text animation stream decoder: predicts each result from the byte stream.
`timescale 1ns / 1ps
module text_animation_stream_decoder_checker
  import tasd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  kind,
  input  logic [7:0]  col,
  input  logic [8:0]  row,
  input  logic [7:0]  char_code,
  input  logic [13:0] delay_ms,
  input  logic        last,
  output int          errors,
  output int          pending,
  output int          checked
);

  localparam logic [3:0] NIB_SPACE_LO  = 4'h8;
  localparam logic [3:0] NIB_SPACE_HI  = 4'h9;
  localparam logic [3:0] NIB_SKIP      = 4'hA;
  localparam logic [3:0] NIB_REPEAT    = 4'hE;
  localparam int         FRAME_TICK_MS = 33;

  typedef enum logic [3:0] {
    PS_MAGIC,
    PS_WIDTH,
    PS_HEIGHT,
    PS_COUNT,
    PS_DATA,
    PS_REPCHAR,
    PS_DELAY,
    PS_HOME,
    PS_HALT
  } parse_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  col;
    logic [8:0]  row;
    logic [7:0]  char_code;
    logic [13:0] delay_ms;
    logic        last;
  } screen_op_t;

  parse_t     ps;
  logic [7:0] win_w;
  logic [7:0] win_h;
  logic [7:0] cur_col;
  logic [8:0] cur_row;
  int         rep_count;
  logic [7:0] frame_n;
  int         n_err;
  int         n_chk;
  screen_op_t byte_ops[$];
  screen_op_t screen_q[$];

  function automatic logic [8:0] bottom_row();
    return {1'b0, win_h} + 9'd1;
  endfunction

  function automatic void post(logic [2:0] k, logic [7:0] c, logic [8:0] r, logic [7:0] ch,
                               logic [13:0] d);
    screen_op_t e;
    e = '{kind: k, col: c, row: r, char_code: ch, delay_ms: d, last: 1'b0};
    byte_ops.push_back(e);
  endfunction

  function automatic void down_one();
    if (cur_row < bottom_row()) cur_row = cur_row + 9'd1;
  endfunction

  function automatic void put_char(logic [7:0] ch);
    post(KIND_CHAR, cur_col, cur_row, ch, 14'd0);
    if (int'(cur_col) + 1 > int'(win_w)) begin
      cur_col = 8'd1;
      down_one();
    end else begin
      cur_col = cur_col + 8'd1;
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int n;
    int pos;
    int cap;
    int r;
    byte_ops.delete();
    case (ps)
      PS_MAGIC: begin
        if (b == MAGIC_BYTE) begin
          ps = PS_WIDTH;
        end else begin
          post(KIND_BAD_MAGIC, 8'd0, 9'd0, 8'd0, 14'd0);
          ps = PS_HALT;
        end
      end
      PS_WIDTH: begin
        win_w = b;
        ps = PS_HEIGHT;
      end
      PS_HEIGHT: begin
        win_h = b;
        ps = PS_COUNT;
      end
      PS_COUNT: begin
        if (b != 8'd0) begin
          post(KIND_USER_CHR, 8'd0, 9'd0, 8'd0, 14'd0);
          ps = PS_HALT;
        end else begin
          ps = PS_DATA;
        end
      end
      PS_DATA: begin
        if (b[7:4] == NIB_SPACE_LO || b[7:4] == NIB_SPACE_HI) begin
          n = int'(b[4:0]) + 2;
          repeat (n) put_char(SPACE_CHAR);
        end else if (b[7:4] == NIB_SKIP) begin
          n = (b[3:0] != 4'd0) ? int'(b[3:0]) : 16;
          pos = int'(cur_col) + n;
          cap = (win_w != 8'd0) ? int'(win_w) : 1;
          if (pos > int'(win_w)) begin
            pos -= int'(win_w);
            down_one();
          end
          if (pos > cap) pos = cap;
          cur_col = pos[7:0];
        end else if (b[7:4] == NIB_REPEAT) begin
          rep_count = (b[3:0] != 4'd0) ? int'(b[3:0]) : 16;
          ps = PS_REPCHAR;
        end else if (b == OPC_END) begin
          post(KIND_MOVIE_END, 8'd0, 9'd0, 8'd0, 14'd0);
          ps = PS_HALT;
        end else if (b == OPC_FRAME) begin
          ps = PS_DELAY;
        end else begin
          put_char(b);
        end
      end
      PS_REPCHAR: begin
        repeat (rep_count) put_char(b);
        rep_count = 0;
        ps = PS_DATA;
      end
      PS_DELAY: begin
        frame_n = b;
        ps = PS_HOME;
      end
      PS_HOME: begin
        r = int'(b) + 1;
        if (r > int'(bottom_row())) r = int'(bottom_row());
        cur_col = 8'd1;
        cur_row = r[8:0];
        post(KIND_FRAME, cur_col, cur_row, 8'd0, 14'(FRAME_TICK_MS * int'(frame_n)));
        ps = PS_DATA;
      end
      default: ps = PS_HALT;
    endcase
    if (byte_ops.size() > 0) byte_ops[byte_ops.size() - 1].last = 1'b1;
    foreach (byte_ops[i]) screen_q.push_back(byte_ops[i]);
  endfunction

  always @(posedge clk) begin : watch_b
    screen_op_t want;
    screen_op_t got;
    if (rst) begin
      ps        = PS_MAGIC;
      win_w     = 8'd0;
      win_h     = 8'd0;
      cur_col   = 8'd1;
      cur_row   = 9'd1;
      rep_count = 0;
      frame_n   = 8'd0;
      n_err     = 0;
      n_chk     = 0;
      screen_q.delete();
    end else begin
      if (in_valid && in_ready) decode_byte(byte_in);
      if (out_valid && out_ready) begin
        got = '{kind: kind, col: col, row: row, char_code: char_code, delay_ms: delay_ms,
                last: last};
        n_chk++;
        if (screen_q.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("[%0t] unexpected result: kind=%0d col=%0d row=%0d char=%02h delay=%0d last=%0b",
                     $time, got.kind, got.col, got.row, got.char_code, got.delay_ms, got.last);
        end else begin
          want = screen_q.pop_front();
          if (got !== want) begin
            n_err++;
            if (n_err <= 10) begin
              $display("[%0t] result %0d mismatch", $time, n_chk);
              $display("  expected kind=%0d col=%0d row=%0d char=%02h delay=%0d last=%0b",
                       want.kind, want.col, want.row, want.char_code, want.delay_ms, want.last);
              $display("  actual   kind=%0d col=%0d row=%0d char=%02h delay=%0d last=%0b",
                       got.kind, got.col, got.row, got.char_code, got.delay_ms, got.last);
            end
          end
        end
      end
    end
    errors  <= n_err;
    checked <= n_chk;
    pending <= screen_q.size();
  end

endmodule

### dv/tb_text_animation_stream_decoder_top.sv
// Testbench top for the text animation stream decoder: byte stream, backpressure and verdict.
`timescale 1ns / 1ps
module tb_text_animation_stream_decoder_top;
  import tasd_pkg::*;

  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         STREAM_BYTES    = 205;
  localparam int         CALM_AFTER      = 180;
  localparam int         HOLD_AFTER      = 60;
  localparam int         HOLD_CYCLES     = 300;
  localparam logic [7:0] OPC_SPACE_BASE  = 8'h80;
  localparam logic [7:0] OPC_SKIP_BASE   = 8'hA0;
  localparam logic [7:0] LIT_HIGH_BASE   = 8'hB0;
  localparam logic [7:0] OPC_REPEAT_BASE = 8'hE0;
  localparam logic [7:0] USER_CHR_NONE   = 8'h00;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  byte_in;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  kind;
  logic [7:0]  col;
  logic [8:0]  row;
  logic [7:0]  char_code;
  logic [13:0] delay_ms;
  logic        last;
  int          errors;
  int          pending;
  int          checked;
  int          bytes_sent = 0;
  int          cycles = 0;
  logic [7:0]  win_w;
  logic [7:0]  win_h;
  bit          held_off;

  text_animation_stream_decoder_top u_top (.*);

  text_animation_stream_decoder_checker u_checker (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b);
    if (bytes_sent < CALM_AFTER && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  initial begin : recv_b
    out_ready <= 1'b0;
    held_off = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held_off && bytes_sent >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (bytes_sent < CALM_AFTER && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin : stim_b
    logic [7:0] b;
    int         pick;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    byte_in  <= 8'd0;
    pick = $urandom_range(0, 7);
    win_w = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 20));
    win_h = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 6));
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_byte(MAGIC_BYTE);
    send_byte(win_w);
    send_byte(win_h);
    send_byte(USER_CHR_NONE);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(LIT_HIGH_BASE);
    send_byte(8'hDF);
    send_byte(8'hF2);
    send_byte(8'hFF);
    send_byte(OPC_SPACE_BASE);
    send_byte(OPC_SPACE_BASE | 8'd31);
    send_byte(OPC_SKIP_BASE);
    send_byte(OPC_SKIP_BASE | 8'd15);
    send_byte(OPC_SKIP_BASE | 8'd1);
    send_byte(OPC_REPEAT_BASE);
    send_byte(OPC_END);
    send_byte(OPC_REPEAT_BASE | 8'd15);
    send_byte(8'hFF);
    send_byte(OPC_FRAME);
    send_byte(8'd0);
    send_byte(8'd0);
    send_byte(OPC_FRAME);
    send_byte(8'hFF);
    send_byte(8'hFF);

    while (bytes_sent < STREAM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        do b = 8'($urandom);
        while ((b >= OPC_SPACE_BASE && b < LIT_HIGH_BASE) ||
               (b >= OPC_REPEAT_BASE && b <= OPC_FRAME));
        send_byte(b);
      end else if (pick < 50) begin
        send_byte(OPC_SPACE_BASE | 8'($urandom_range(0, 31)));
      end else if (pick < 62) begin
        send_byte(OPC_SKIP_BASE | 8'($urandom_range(0, 15)));
      end else if (pick < 82) begin
        send_byte(OPC_REPEAT_BASE | 8'($urandom_range(0, 15)));
        send_byte(8'($urandom));
      end else if (pick < 92) begin
        send_byte(OPC_FRAME);
        send_byte(8'($urandom));
        send_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8)) : 8'($urandom));
      end else begin
        do b = 8'($urandom);
        while (b >= OPC_REPEAT_BASE && b <= OPC_FRAME);
        send_byte(b);
      end
    end

    send_byte(OPC_END);
    repeat (3) send_byte(8'($urandom));
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);

    $display("Sent %0d stream bytes into a %0d-column, %0d-row window: header, every opcode class,",
             bytes_sent, win_w, win_h + 1);
    $display("random runs, repeats and frame ends, movie end, trailing bytes; %0d results compared, %0d bad.",
             checked, errors + pending);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### text_animation_stream_decoder_top.f
rtl/core/tasd_pkg.sv
rtl/core/tasd_front.sv
rtl/core/tasd_fifo.sv
rtl/core/tasd_back.sv
rtl/core/text_animation_stream_decoder_top.sv
dv/text_animation_stream_decoder_checker.sv
dv/tb_text_animation_stream_decoder_top.sv
